@@ rtl/fmn_pkg.sv @@
// shared constants and codes for the min/max feature normalizer
package fmn_pkg;

  // field widths
  localparam int IDX_W   = 6;
  localparam int VAL_W   = 32;
  localparam int WGT_W   = 18;
  localparam int TGT_W   = 16;
  localparam int REQ_W   = 2;
  localparam int ST_W    = 2;
  localparam int CFG_IW  = 1;

  // default number of feature dimensions
  localparam int NUM_DIMS_DEF = 64;

  // request codes
  localparam logic [REQ_W-1:0] REQ_ACC   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_APPLY = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;
  localparam logic [REQ_W-1:0] REQ_NOP   = 2'd3;

  // status codes
  localparam logic [ST_W-1:0] ST_OK         = 2'd0;
  localparam logic [ST_W-1:0] ST_LOW_WEIGHT = 2'd1;
  localparam logic [ST_W-1:0] ST_ZERO_RANGE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IW-1:0] CFG_LOW_TARGET  = 1'b0;
  localparam logic [CFG_IW-1:0] CFG_HIGH_TARGET = 1'b1;

  // register reset values
  localparam logic [TGT_W-1:0] LOW_TARGET_RST  = 16'd655;
  localparam logic [TGT_W-1:0] HIGH_TARGET_RST = 16'd64881;

  // q-format constants
  localparam logic [VAL_W-1:0] Q_ONE   = 32'h0001_0000;
  localparam logic [VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
  localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;

  // divider: numerator magnitude bits, one quotient bit per step
  localparam int DIV_STEPS = 50;
  localparam int DIV_CW    = 6;

endpackage

@@ rtl/fmn_ifs.sv @@
// channel interfaces: request input, result output, configuration write

interface fmn_in_if;
  logic                          valid;
  logic                          ready;
  logic [fmn_pkg::REQ_W-1:0]     req_type;
  logic [fmn_pkg::IDX_W-1:0]     element_index;
  logic signed [fmn_pkg::VAL_W-1:0] feature_value;
  logic [fmn_pkg::WGT_W-1:0]     weight;

  modport source (output valid, req_type, element_index, feature_value, weight,
                  input ready);
  modport sink   (input valid, req_type, element_index, feature_value, weight,
                  output ready);
endinterface

interface fmn_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [fmn_pkg::VAL_W-1:0] norm_value;
  logic [fmn_pkg::ST_W-1:0]         status;

  modport source (output valid, norm_value, status, input ready);
  modport sink   (input valid, norm_value, status, output ready);
endinterface

interface fmn_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [fmn_pkg::CFG_IW-1:0]    index;
  logic [fmn_pkg::TGT_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/feature_minmax_normalizer_core.sv @@
// top level of the weighted min/max feature normalizer
//
// usage
// - in_chan: one request per transfer (accumulate, apply, clear, no-op); every
//   request gives exactly one transfer on out_chan, in request order
// - cfg_chan: writes low_target (index 0) and high_target (index 1); always
//   ready, write only while no request is in flight
// - steps from input transfer to the output register: apply checks the range,
//   forms the numerator, divides bit-serially and rounds; accumulate multiplies
//   and folds; clear sweeps memory; rejected or trivial requests go to S_DONE
// - one request at a time; in_chan.ready is low while a request is worked
//   on, so a new request is taken only once the last one is in the output register
// - the min/max pair of each dimension lives in one memory word; after reset
//   and on every clear a sweep rewrites all NUM_DIMS words, with
//   in_chan not ready meanwhile
// - the output register holds a finished result while out_chan stalls; the
//   next request is still taken, and its result waits in the last step until
//   the register frees up
module feature_minmax_normalizer_core #(
  parameter int NUM_DIMS = fmn_pkg::NUM_DIMS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  fmn_in_if.sink     in_chan,
  fmn_out_if.source  out_chan,
  fmn_cfg_if.sink    cfg_chan
);

  localparam int AW = (NUM_DIMS > 1) ? $clog2(NUM_DIMS) : 1;
  localparam int MW = 2 * fmn_pkg::VAL_W;

  // sequencer codes
  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_MUL  = 4'd2;
  localparam logic [3:0] S_ACC  = 4'd3;
  localparam logic [3:0] S_RNG  = 4'd4;
  localparam logic [3:0] S_APM  = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_RND  = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  // control state
  logic [3:0]                    state_r, state_nxt;
  logic [AW-1:0]                 clr_cnt_r, clr_cnt_nxt;
  logic                          clr_res_r, clr_res_nxt;
  logic [fmn_pkg::DIV_CW-1:0]    div_cnt_r, div_cnt_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [fmn_pkg::VAL_W-1:0]     wtot_r, wtot_nxt;
  logic [fmn_pkg::TGT_W-1:0]     low_r, high_r;

  // payload registers
  logic [fmn_pkg::IDX_W-1:0]        idx_r, idx_nxt;
  logic signed [fmn_pkg::VAL_W-1:0] feat_r, feat_nxt;
  logic [fmn_pkg::WGT_W-1:0]        wgt_r, wgt_nxt;
  logic signed [50:0]               prod_r, prod_nxt;
  logic signed [32:0]               diff_r, diff_nxt;
  logic [31:0]                      den_r, den_nxt;
  logic                             neg_r, neg_nxt;
  logic [49:0]                      quo_r, quo_nxt;
  logic [31:0]                      rem_r, rem_nxt;
  logic signed [fmn_pkg::VAL_W-1:0] res_val_r, res_val_nxt;
  logic [fmn_pkg::ST_W-1:0]         res_st_r, res_st_nxt;
  logic signed [fmn_pkg::VAL_W-1:0] out_val_r, out_val_nxt;
  logic [fmn_pkg::ST_W-1:0]         out_st_r, out_st_nxt;

  // statistics memory: {max, min} per dimension
  logic [MW-1:0] stat_mem [NUM_DIMS];
  logic [MW-1:0] mem_rd_r;
  logic          mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [MW-1:0] mem_wd;

  // datapath terms
  logic signed [50:0] rnd_sum;
  logic signed [34:0] acc_r35;
  logic signed [31:0] acc_val;
  logic signed [31:0] cur_min, cur_max;
  logic signed [32:0] range33;
  logic signed [16:0] span;
  logic signed [49:0] num;
  logic [32:0]        trial;
  logic               q_bit;
  logic               round_up;
  logic [50:0]        q51;
  logic signed [51:0] sq, total;
  logic [32:0]        wsum;
  logic               in_xfer, out_free, idx_in_ok;

  assign in_chan.ready   = (state_r == S_IDLE);
  assign in_xfer         = in_chan.valid && in_chan.ready;
  assign out_free        = !out_valid_r || out_chan.ready;
  assign idx_in_ok       = (32'(in_chan.element_index) < NUM_DIMS);

  assign out_chan.valid      = out_valid_r;
  assign out_chan.norm_value = out_val_r;
  assign out_chan.status     = out_st_r;

  assign cfg_chan.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= fmn_pkg::LOW_TARGET_RST;
      high_r <= fmn_pkg::HIGH_TARGET_RST;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      case (cfg_chan.index)
        fmn_pkg::CFG_LOW_TARGET:  low_r  <= cfg_chan.data;
        fmn_pkg::CFG_HIGH_TARGET: high_r <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  // memory port: read address follows the incoming index while idle
  assign mem_ra = (state_r == S_IDLE) ? AW'(in_chan.element_index) : AW'(idx_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stat_mem[mem_wa] <= mem_wd;
    end
    mem_rd_r <= stat_mem[mem_ra];
  end

  assign cur_min = mem_rd_r[fmn_pkg::VAL_W-1:0];
  assign cur_max = mem_rd_r[MW-1:fmn_pkg::VAL_W];

  // weighted product, rounded half up to q15.16, saturated
  assign rnd_sum = prod_r + 51'sd32768;
  assign acc_r35 = 35'(rnd_sum >>> 16);
  always_comb begin
    if (acc_r35 > 35'sh0_7FFF_FFFF) begin
      acc_val = $signed(fmn_pkg::VAL_MAX);
    end else if (acc_r35 < -35'sh0_8000_0000) begin
      acc_val = $signed(fmn_pkg::VAL_MIN);
    end else begin
      acc_val = acc_r35[31:0];
    end
  end

  // apply terms
  assign range33 = 33'(cur_max) - 33'(cur_min);
  assign span    = $signed({1'b0, high_r}) - $signed({1'b0, low_r});
  assign num     = 50'(diff_r) * 50'(span);

  // restoring divider step
  assign trial = {rem_r, quo_r[49]};
  assign q_bit = (trial >= {1'b0, den_r});

  // round to nearest, ties away from zero, then offset and saturate
  assign round_up = ({rem_r, 1'b0} >= {1'b0, den_r});
  assign q51      = {1'b0, quo_r} + 51'(round_up);
  assign sq       = neg_r ? -$signed({1'b0, q51}) : $signed({1'b0, q51});
  assign total    = sq + $signed({36'd0, low_r});

  assign wsum = {1'b0, wtot_r} + 33'(wgt_r);

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    clr_res_nxt   = clr_res_r;
    div_cnt_nxt   = div_cnt_r;
    out_valid_nxt = out_valid_r;
    wtot_nxt      = wtot_r;
    idx_nxt       = idx_r;
    feat_nxt      = feat_r;
    wgt_nxt       = wgt_r;
    prod_nxt      = prod_r;
    diff_nxt      = diff_r;
    den_nxt       = den_r;
    neg_nxt       = neg_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    res_val_nxt   = res_val_r;
    res_st_nxt    = res_st_r;
    out_val_nxt   = out_val_r;
    out_st_nxt    = out_st_r;
    mem_we        = 1'b0;
    mem_wa        = AW'(idx_r);
    mem_wd        = mem_rd_r;

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      // rewrite every dimension with its empty min/max pair
      S_CLR: begin
        mem_we      = 1'b1;
        mem_wa      = clr_cnt_r;
        mem_wd      = {fmn_pkg::VAL_MIN, fmn_pkg::VAL_MAX};
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(NUM_DIMS - 1)) begin
          clr_cnt_nxt = '0;
          state_nxt   = clr_res_r ? S_DONE : S_IDLE;
          clr_res_nxt = 1'b0;
        end
      end

      S_IDLE: begin
        if (in_xfer) begin
          idx_nxt     = in_chan.element_index;
          feat_nxt    = in_chan.feature_value;
          wgt_nxt     = in_chan.weight;
          res_val_nxt = '0;
          res_st_nxt  = fmn_pkg::ST_OK;
          state_nxt   = S_DONE;
          case (in_chan.req_type)
            fmn_pkg::REQ_ACC: begin
              if (in_chan.weight != '0 && idx_in_ok) begin
                state_nxt = S_MUL;
              end
            end
            fmn_pkg::REQ_APPLY: begin
              if (wtot_r < fmn_pkg::Q_ONE) begin
                res_st_nxt = fmn_pkg::ST_LOW_WEIGHT;
              end else if (!idx_in_ok) begin
                res_st_nxt = fmn_pkg::ST_ZERO_RANGE;
              end else begin
                state_nxt = S_RNG;
              end
            end
            fmn_pkg::REQ_CLEAR: begin
              wtot_nxt    = '0;
              clr_cnt_nxt = '0;
              clr_res_nxt = 1'b1;
              state_nxt   = S_CLR;
            end
            default: ;
          endcase
        end
      end

      S_MUL: begin
        prod_nxt  = 51'(feat_r) * 51'($signed({1'b0, wgt_r}));
        state_nxt = S_ACC;
      end

      // fold the weighted value into min/max, total on dimension zero
      S_ACC: begin
        mem_we = 1'b1;
        mem_wd = {(acc_val > cur_max) ? acc_val : cur_max,
                  (acc_val < cur_min) ? acc_val : cur_min};
        if (idx_r == '0) begin
          wtot_nxt = wsum[32] ? '1 : wsum[31:0];
        end
        state_nxt = S_DONE;
      end

      S_RNG: begin
        if (range33 <= 33'sd0) begin
          res_st_nxt = fmn_pkg::ST_ZERO_RANGE;
          state_nxt  = S_DONE;
        end else begin
          den_nxt   = range33[31:0];
          diff_nxt  = 33'(feat_r) - 33'(cur_min);
          state_nxt = S_APM;
        end
      end

      S_APM: begin
        neg_nxt     = num[49];
        quo_nxt     = num[49] ? 50'(-num) : 50'(num);
        rem_nxt     = '0;
        div_cnt_nxt = '0;
        state_nxt   = S_DIV;
      end

      // one quotient bit per cycle
      S_DIV: begin
        rem_nxt     = q_bit ? 32'(trial - {1'b0, den_r}) : trial[31:0];
        quo_nxt     = {quo_r[48:0], q_bit};
        div_cnt_nxt = div_cnt_r + fmn_pkg::DIV_CW'(1);
        if (div_cnt_r == fmn_pkg::DIV_CW'(fmn_pkg::DIV_STEPS - 1)) begin
          state_nxt = S_RND;
        end
      end

      S_RND: begin
        if (total > 52'sh0_0000_7FFF_FFFF) begin
          res_val_nxt = $signed(fmn_pkg::VAL_MAX);
        end else if (total < -52'sh0_0000_8000_0000) begin
          res_val_nxt = $signed(fmn_pkg::VAL_MIN);
        end else begin
          res_val_nxt = total[31:0];
        end
        state_nxt = S_DONE;
      end

      // hand the result to the output register once it is free
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = res_val_r;
          out_st_nxt    = res_st_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      clr_res_r   <= 1'b0;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      wtot_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_res_r   <= clr_res_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      wtot_r      <= wtot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    feat_r    <= feat_nxt;
    wgt_r     <= wgt_nxt;
    prod_r    <= prod_nxt;
    diff_r    <= diff_nxt;
    den_r     <= den_nxt;
    neg_r     <= neg_nxt;
    quo_r     <= quo_nxt;
    rem_r     <= rem_nxt;
    res_val_r <= res_val_nxt;
    res_st_r  <= res_st_nxt;
    out_val_r <= out_val_nxt;
    out_st_r  <= out_st_nxt;
  end

endmodule

@@ tb/fmn_result_checker.sv @@
// result checker for the min/max feature normalizer: predicts each result and compares it
module fmn_result_checker #(
  parameter int NUM_DIMS = fmn_pkg::NUM_DIMS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  fmn_in_if    in_mon,
  fmn_out_if   out_mon,
  fmn_cfg_if   cfg_mon,
  output int   fail_count,
  output int   results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [fmn_pkg::VAL_W-1:0] value;
    logic [fmn_pkg::ST_W-1:0]         status;
  } norm_result_t;

  // running statistics and targets as the block should hold them
  logic signed [fmn_pkg::VAL_W-1:0] dim_min [NUM_DIMS];
  logic signed [fmn_pkg::VAL_W-1:0] dim_max [NUM_DIMS];
  logic [fmn_pkg::VAL_W-1:0]        wt_sum;
  logic [fmn_pkg::TGT_W-1:0]        tgt_lo;
  logic [fmn_pkg::TGT_W-1:0]        tgt_hi;

  norm_result_t norm_q [$];
  int n_fail = 0;

  function automatic logic signed [fmn_pkg::VAL_W-1:0] clamp_q15(input longint v);
    if (v > 64'sd2147483647) return fmn_pkg::VAL_MAX;
    if (v < -64'sd2147483648) return fmn_pkg::VAL_MIN;
    return v[fmn_pkg::VAL_W-1:0];
  endfunction

  always @(posedge clk) begin : track
    longint prod, sum, rng, num, mag, quo;
    norm_result_t want, got;
    int d;
    if (!rst_n) begin
      for (int i = 0; i < NUM_DIMS; i++) begin
        dim_min[i] = fmn_pkg::VAL_MAX;
        dim_max[i] = fmn_pkg::VAL_MIN;
      end
      wt_sum = '0;
      tgt_lo = fmn_pkg::LOW_TARGET_RST;
      tgt_hi = fmn_pkg::HIGH_TARGET_RST;
      norm_q.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          fmn_pkg::CFG_LOW_TARGET:  tgt_lo = cfg_mon.data;
          fmn_pkg::CFG_HIGH_TARGET: tgt_hi = cfg_mon.data;
          default: ;
        endcase
      end

      // compare first, the result leaving now belongs to an older request
      if (out_mon.valid && out_mon.ready) begin
        got.value  = out_mon.norm_value;
        got.status = out_mon.status;
        if (norm_q.size() == 0) begin
          $error("result transfer with nothing expected: norm_value %0d status %0d",
                 got.value, got.status);
          n_fail++;
        end else begin
          want = norm_q.pop_front();
          if (got.value !== want.value) begin
            $error("norm_value: expected %0d, actual %0d", want.value, got.value);
            n_fail++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            n_fail++;
          end
        end
      end

      if (in_mon.valid && in_mon.ready) begin
        want.value  = '0;
        want.status = fmn_pkg::ST_OK;
        d = int'(in_mon.element_index);
        case (in_mon.req_type)
          fmn_pkg::REQ_ACC: begin
            if (in_mon.weight != '0 && d < NUM_DIMS) begin
              // Q15.16 * Q2.16, round half up back to Q15.16
              prod = longint'(in_mon.feature_value) * longint'(in_mon.weight);
              prod = (prod + 64'sd32768) >>> 16;
              if (clamp_q15(prod) < dim_min[d]) dim_min[d] = clamp_q15(prod);
              if (clamp_q15(prod) > dim_max[d]) dim_max[d] = clamp_q15(prod);
              if (d == 0) begin
                sum = longint'(wt_sum) + longint'(in_mon.weight);
                wt_sum = (sum > 64'sd4294967295) ? '1 : sum[fmn_pkg::VAL_W-1:0];
              end
            end
          end
          fmn_pkg::REQ_APPLY: begin
            if (wt_sum < fmn_pkg::Q_ONE) begin
              want.status = fmn_pkg::ST_LOW_WEIGHT;
            end else if (d >= NUM_DIMS) begin
              want.status = fmn_pkg::ST_ZERO_RANGE;
            end else begin
              rng = longint'(dim_max[d]) - longint'(dim_min[d]);
              if (rng <= 0) begin
                want.status = fmn_pkg::ST_ZERO_RANGE;
              end else begin
                num = (longint'(in_mon.feature_value) - longint'(dim_min[d])) *
                      (longint'(tgt_hi) - longint'(tgt_lo));
                mag = (num < 0) ? -num : num;
                // nearest, ties away from zero
                quo = (2 * mag + rng) / (2 * rng);
                want.value = clamp_q15(longint'(tgt_lo) + ((num < 0) ? -quo : quo));
              end
            end
          end
          fmn_pkg::REQ_CLEAR: begin
            for (int i = 0; i < NUM_DIMS; i++) begin
              dim_min[i] = fmn_pkg::VAL_MAX;
              dim_max[i] = fmn_pkg::VAL_MIN;
            end
            wt_sum = '0;
          end
          fmn_pkg::REQ_NOP: ;
          default: ;
        endcase
        norm_q.push_back(want);
      end
    end
    fail_count      <= n_fail;
    results_pending <= norm_q.size();
  end

endmodule

@@ tb/feature_minmax_normalizer_core_test.sv @@
// testbench top for the min/max feature normalizer: stimulus, flow control and verdict
module feature_minmax_normalizer_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_PHASES     = 5;
  localparam int RAND_PER_PHASE = 266;
  // the last stretch of the final phase runs without any idling
  localparam int CALM_TAIL      = 120;
  // watchdog limit; this leaves a wide margin over the slowest request
  localparam int CYCLE_LIMIT    = 1_000_000;
  // longer than the slowest request (clear sweep) after the last result
  localparam int SETTLE_CYCLES  = 80;

  logic clk;
  logic rst_n;

  fmn_in_if  in_chan ();
  fmn_out_if out_chan ();
  fmn_cfg_if cfg_chan ();

  int fail_count;
  int results_pending;
  int cycle_count = 0;
  int rx_hold = 0;
  logic tx_idle_on = 1'b1;
  logic rx_idle_on = 1'b1;
  logic calm = 1'b0;

  feature_minmax_normalizer_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  fmn_result_checker chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_chan),
    .out_mon         (out_chan),
    .cfg_mon         (cfg_chan),
    .fail_count      (fail_count),
    .results_pending (results_pending)
  );

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // cycle count, watchdog, and the on/off pattern of idling on both sides
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    // whenever the low byte of the cycle count is zero, each side decides whether it idles at all for a while
    if (cycle_count[7:0] == 8'd0) begin
      tx_idle_on <= ($urandom_range(0, 3) != 0);
      rx_idle_on <= ($urandom_range(0, 3) != 0);
    end
    if (cycle_count == CYCLE_LIMIT) begin
      $display("feature_minmax_normalizer_core_test: done, errors");
      $finish;
    end
  end

  // result side: random stall bursts on out_chan.ready, timed by rx_hold
  always @(posedge clk) begin
    if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
      out_chan.ready <= 1'b0;
    end else if (!calm && rx_idle_on && $urandom_range(0, 5) == 0) begin
      rx_hold <= $urandom_range(0, 13);
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  // one request transfer; valid stays high afterward unless a gap or a drain follows
  task automatic send_req(input logic [fmn_pkg::REQ_W-1:0] req,
                          input logic [fmn_pkg::IDX_W-1:0] idx,
                          input logic [fmn_pkg::VAL_W-1:0] feat,
                          input logic [fmn_pkg::WGT_W-1:0] wgt);
    if (!calm && tx_idle_on && $urandom_range(0, 4) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.req_type      <= req;
    in_chan.element_index <= idx;
    in_chan.feature_value <= feat;
    in_chan.weight        <= wgt;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  // stop sending and wait until every result has come back
  task automatic wait_results_done();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
  endtask

  // both target registers, back to back; the block is idle here
  task automatic set_targets(input logic [fmn_pkg::TGT_W-1:0] lo,
                             input logic [fmn_pkg::TGT_W-1:0] hi);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= fmn_pkg::CFG_LOW_TARGET;
    cfg_chan.data  <= lo;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    cfg_chan.index <= fmn_pkg::CFG_HIGH_TARGET;
    cfg_chan.data  <= hi;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    cfg_chan.valid <= 1'b0;
  endtask

  // random request, biased toward a few dimensions and index 0 so that the
  // weight total passes one and the dimensions build up a real range
  task automatic send_random_req();
    logic [fmn_pkg::REQ_W-1:0] req;
    logic [fmn_pkg::IDX_W-1:0] idx;
    logic [fmn_pkg::VAL_W-1:0] feat;
    logic [fmn_pkg::WGT_W-1:0] wgt;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) req = fmn_pkg::REQ_ACC;
    else if (pick < 92) req = fmn_pkg::REQ_APPLY;
    else if (pick < 95) req = fmn_pkg::REQ_CLEAR;
    else req = fmn_pkg::REQ_NOP;

    pick = $urandom_range(0, 9);
    if (pick < 3) idx = '0;
    else if (pick < 8) idx = fmn_pkg::IDX_W'($urandom_range(0, 7));
    else idx = fmn_pkg::IDX_W'($urandom_range(0, fmn_pkg::NUM_DIMS_DEF - 1));

    pick = $urandom_range(0, 9);
    if (pick == 0) feat = fmn_pkg::VAL_MAX;
    else if (pick == 1) feat = fmn_pkg::VAL_MIN;
    else if (pick < 6) feat = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    else feat = $urandom;

    pick = $urandom_range(0, 9);
    if (pick == 0) wgt = '0;
    else if (pick == 1) wgt = '1;
    else if (pick == 2) wgt = 18'd1;
    else if (pick < 6) wgt = fmn_pkg::WGT_W'($urandom_range(18'h0_8000, 18'h1_8000));
    else wgt = fmn_pkg::WGT_W'($urandom);

    send_req(req, idx, feat, wgt);
  endtask

  initial begin
    logic [fmn_pkg::TGT_W-1:0] lo_set [NUM_PHASES];
    logic [fmn_pkg::TGT_W-1:0] hi_set [NUM_PHASES];
    logic [fmn_pkg::TGT_W-1:0] same_tgt;

    // every block input known from time zero, result ready from the first edge
    rst_n                 <= 1'b0;
    in_chan.valid         <= 1'b0;
    in_chan.req_type      <= fmn_pkg::REQ_NOP;
    in_chan.element_index <= '0;
    in_chan.feature_value <= '0;
    in_chan.weight        <= '0;
    cfg_chan.valid        <= 1'b0;
    cfg_chan.index        <= fmn_pkg::CFG_LOW_TARGET;
    cfg_chan.data         <= '0;

    // target settings per phase: reset values, full span, reversed span,
    // zero span, random
    same_tgt  = fmn_pkg::TGT_W'($urandom);
    lo_set[0] = fmn_pkg::LOW_TARGET_RST;  hi_set[0] = fmn_pkg::HIGH_TARGET_RST;
    lo_set[1] = '0;                       hi_set[1] = '1;
    lo_set[2] = '1;                       hi_set[2] = '0;
    lo_set[3] = same_tgt;                 hi_set[3] = same_tgt;
    lo_set[4] = fmn_pkg::TGT_W'($urandom);
    hi_set[4] = fmn_pkg::TGT_W'($urandom);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // the block sweeps its statistics memory after reset; ready tells us when

    // directed part with the reset targets
    // apply while the weight total is still zero
    send_req(fmn_pkg::REQ_APPLY, 6'd3, '0, '0);
    send_req(fmn_pkg::REQ_NOP, 6'd63, fmn_pkg::VAL_MAX, '1);
    // zero weight leaves everything untouched
    send_req(fmn_pkg::REQ_ACC, 6'd0, 32'h0001_0000, '0);
    // weight on a nonzero index does not count toward the total
    send_req(fmn_pkg::REQ_ACC, 6'd5, 32'h0001_0000, 18'h1_0000);
    send_req(fmn_pkg::REQ_APPLY, 6'd5, '0, '0);
    // products that saturate both ways on index 0, total goes past one
    send_req(fmn_pkg::REQ_ACC, 6'd0, fmn_pkg::VAL_MAX, '1);
    send_req(fmn_pkg::REQ_ACC, 6'd0, fmn_pkg::VAL_MIN, '1);
    send_req(fmn_pkg::REQ_APPLY, 6'd0, fmn_pkg::VAL_MAX, '0);
    send_req(fmn_pkg::REQ_APPLY, 6'd0, fmn_pkg::VAL_MIN, '0);
    send_req(fmn_pkg::REQ_APPLY, 6'd0, '0, '0);
    // one sample only gives a zero range, an untouched dimension an empty one
    send_req(fmn_pkg::REQ_APPLY, 6'd5, 32'h0001_0000, '0);
    send_req(fmn_pkg::REQ_APPLY, 6'd20, '0, '0);
    // range of one lsb: results saturate at both ends
    send_req(fmn_pkg::REQ_ACC, 6'd63, 32'h0001_0000, 18'h1_0000);
    send_req(fmn_pkg::REQ_ACC, 6'd63, 32'h0001_0001, 18'h1_0000);
    send_req(fmn_pkg::REQ_APPLY, 6'd63, fmn_pkg::VAL_MAX, '1);
    send_req(fmn_pkg::REQ_APPLY, 6'd63, fmn_pkg::VAL_MIN, '1);
    send_req(fmn_pkg::REQ_APPLY, 6'd63, 32'h0001_0001, '0);
    // rounding of tiny products: negative rounds to zero, half rounds up
    send_req(fmn_pkg::REQ_ACC, 6'd7, 32'hFFFF_FFFD, 18'd1);
    send_req(fmn_pkg::REQ_ACC, 6'd7, 32'h0000_8000, 18'd1);
    send_req(fmn_pkg::REQ_APPLY, 6'd7, 32'hFFFF_0000, '0);
    // clear brings back the reset contents
    send_req(fmn_pkg::REQ_CLEAR, '1, '1, '1);
    send_req(fmn_pkg::REQ_APPLY, 6'd0, '0, '0);
    send_req(fmn_pkg::REQ_NOP, '0, '0, '0);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph != 0) begin
        // targets change only with nothing in flight
        wait_results_done();
        set_targets(lo_set[ph], hi_set[ph]);
      end
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        if (ph == NUM_PHASES - 1 && n >= RAND_PER_PHASE - CALM_TAIL) calm = 1'b1;
        send_random_req();
      end
    end

    wait_results_done();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("feature_minmax_normalizer_core_test: done, clean");
    end else begin
      $display("feature_minmax_normalizer_core_test: done, errors");
    end
    $finish;
  end

endmodule

@@ feature_minmax_normalizer_core.f @@
rtl/fmn_pkg.sv
rtl/fmn_ifs.sv
rtl/feature_minmax_normalizer_core.sv
tb/fmn_result_checker.sv
tb/feature_minmax_normalizer_core_test.sv
